FILE: design/wkb_pkg.sv
// ----------------------------------------------------------------------------
// WKB ZM linestring parser package
// Shared types, phase codes and status codes.
// ----------------------------------------------------------------------------
package wkb_pkg;

    typedef enum logic [3:0] {
        PH_OUTER_ENDIAN = 4'd0,
        PH_OUTER_TYPE   = 4'd1,
        PH_OUTER_SRID   = 4'd2,
        PH_NLINES       = 4'd3,
        PH_SUB_ENDIAN   = 4'd4,
        PH_SUB_TYPE     = 4'd5,
        PH_SUB_SRID     = 4'd6,
        PH_NPOINTS      = 4'd7,
        PH_COORD        = 4'd8
    } t_phase;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_TRUNC  = 3'd1;
    localparam logic [2:0] ST_ENDIAN = 3'd2;
    localparam logic [2:0] ST_NOT_ZM = 3'd3;
    localparam logic [2:0] ST_UNSUP  = 3'd4;

    localparam logic KIND_VERTEX = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // One output beat
    typedef struct packed {
        logic        item_kind;
        logic [2:0]  status_code;
        logic [31:0] line_index;
        logic [31:0] point_index;
        logic [63:0] x_bits;
        logic [63:0] y_bits;
        logic [63:0] z_bits;
        logic [63:0] m_bits;
        logic        last_of_run;
    } t_result;

    // One queue entry: results caused by one byte (up to a vertex and a status)
    typedef struct packed {
        logic        has_vertex;
        logic        has_status;
        logic [2:0]  status_code;
        logic [31:0] line_index;
        logic [31:0] point_index;
        logic [63:0] x_bits;
        logic [63:0] y_bits;
        logic [63:0] z_bits;
        logic [63:0] m_bits;
    } t_event;

    localparam int QDEPTH = 2;

endpackage

FILE: design/wkb_if.sv
// ----------------------------------------------------------------------------
// WKB stream interfaces
// Valid/ready channels for input bytes and output results.
// ----------------------------------------------------------------------------
interface wkb_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_stream;
    modport source (output valid, output data_byte, output end_of_stream, input ready);
    modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface wkb_result_if;
    logic        valid;
    logic        ready;
    logic        item_kind;
    logic [2:0]  status_code;
    logic [31:0] line_index;
    logic [31:0] point_index;
    logic [63:0] x_bits;
    logic [63:0] y_bits;
    logic [63:0] z_bits;
    logic [63:0] m_bits;
    logic        last_of_run;
    modport source (output valid, output item_kind, output status_code, output line_index,
                    output point_index, output x_bits, output y_bits, output z_bits,
                    output m_bits, output last_of_run, input ready);
    modport sink   (input valid, input item_kind, input status_code, input line_index,
                    input point_index, input x_bits, input y_bits, input z_bits,
                    input m_bits, input last_of_run, output ready);
endinterface

FILE: design/wkb_zm_linestring_parser.sv
// ----------------------------------------------------------------------------
// WKB ZM linestring parser, top level
// Byte-serial parse of LINESTRING/MULTILINESTRING ZM with vertex and status out.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while the queue is not full; each byte's results
// are registered in the queue. A byte that yields a vertex and a status takes two
// output beats; the two-entry queue between the parser and the serializer absorbs
// that and output stalls. Input ready drops only when the queue is full.
// Reset (i_rst_n low, synchronous) returns the parser to the outer endian byte
// and empties the queue; the last byte of a stream does the same for the parser.
module wkb_zm_linestring_parser (
    input  logic          i_clk,
    input  logic          i_rst_n,
    wkb_byte_if.sink      in_ch,
    wkb_result_if.source  out_ch
);

    wkb_pkg::t_event ev;
    logic            ev_any;
    logic            full;
    logic            take;

    // A byte is taken whenever the queue has room for its results.
    assign in_ch.ready = !full;
    assign take        = in_ch.valid && in_ch.ready;

    wkb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_byte      (in_ch.data_byte),
        .i_last      (in_ch.end_of_stream),
        .o_event     (ev),
        .o_event_any (ev_any)
    );

    wkb_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (ev_any),
        .i_event (ev),
        .o_full  (full),
        .res     (out_ch)
    );

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_ch.valid && !out_ch.ready) |=> out_ch.valid)
        else $error("result beat dropped");

endmodule

FILE: design/wkb_front.sv
// ----------------------------------------------------------------------------
// WKB front end
// Per-byte parser: word assembly, header classification, vertex collection.
// ----------------------------------------------------------------------------
module wkb_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic [7:0]        i_byte,
    input  logic              i_last,
    output wkb_pkg::t_event   o_event,
    output logic              o_event_any
);

    wkb_pkg::t_phase r_phase, n_phase;
    logic [2:0]  r_pos, n_pos;
    logic        r_big, n_big;
    logic [63:0] r_asm, n_asm;
    logic [31:0] r_type, n_type;
    logic        r_multi, n_multi;
    logic [31:0] r_lines, n_lines;
    logic [31:0] r_pts, n_pts;
    logic [31:0] r_line, n_line;
    logic [31:0] r_point, n_point;
    logic [1:0]  r_csel, n_csel;
    logic [63:0] r_held [3];
    logic        r_fin, n_fin;

    // gather
    logic [63:0] g_base, g_word;
    logic [2:0]  g_pos1;
    logic        g_done4, g_done8;
    logic [31:0] g_w32;

    always_comb begin
        g_base = (r_pos == 3'd0) ? 64'd0 : r_asm;
        if (r_big) g_word = {g_base[55:0], i_byte};
        else       g_word = g_base | ({56'd0, i_byte} << {r_pos, 3'b000});
        g_pos1  = r_pos + 3'd1;
        g_done4 = (r_pos == 3'd3);
        g_done8 = (r_pos == 3'd7);
        g_w32   = g_word[31:0];
    end

    // classification of a type word
    logic        c_sub;
    logic [31:0] c_t, c_base;
    logic        c_hz, c_hm;

    always_comb begin
        c_hz   = c_t[31];
        c_hm   = c_t[30];
        c_base = {24'd0, c_t[7:0]};
        if (!c_hz && !c_hm && c_t >= 32'd3000) begin
            c_base = c_t - 32'd3000; c_hz = 1'b1; c_hm = 1'b1;
        end else if (c_sub && !c_hz && !c_hm && c_t >= 32'd2000) begin
            c_base = c_t - 32'd2000; c_hm = 1'b1;
        end else if (c_sub && !c_hz && !c_hm && c_t >= 32'd1000) begin
            c_base = c_t - 32'd1000; c_hz = 1'b1;
        end
    end

    logic        ev_vtx, ev_st;
    logic [2:0]  ev_code;
    logic        hold_we;

    always_comb begin
        n_phase = r_phase; n_pos = r_pos; n_big = r_big; n_asm = r_asm;
        n_type = r_type; n_multi = r_multi; n_lines = r_lines; n_pts = r_pts;
        n_line = r_line; n_point = r_point; n_csel = r_csel; n_fin = r_fin;
        ev_vtx = 1'b0; ev_st = 1'b0; ev_code = wkb_pkg::ST_OK; hold_we = 1'b0;
        c_sub = (r_phase == wkb_pkg::PH_SUB_TYPE) || (r_phase == wkb_pkg::PH_SUB_SRID);
        c_t = (r_phase == wkb_pkg::PH_OUTER_TYPE || r_phase == wkb_pkg::PH_SUB_TYPE)
              ? g_w32 : r_type;
        if (!r_fin) begin
            unique case (r_phase)
                wkb_pkg::PH_OUTER_ENDIAN, wkb_pkg::PH_SUB_ENDIAN: begin
                    if (i_byte > 8'd1) begin
                        ev_st = 1'b1; ev_code = wkb_pkg::ST_ENDIAN;
                    end else begin
                        n_big = (i_byte == 8'd0);
                        n_pos = 3'd0;
                        n_phase = (r_phase == wkb_pkg::PH_OUTER_ENDIAN)
                                  ? wkb_pkg::PH_OUTER_TYPE : wkb_pkg::PH_SUB_TYPE;
                    end
                end
                wkb_pkg::PH_OUTER_TYPE, wkb_pkg::PH_SUB_TYPE,
                wkb_pkg::PH_OUTER_SRID, wkb_pkg::PH_SUB_SRID: begin
                    n_asm = g_word;
                    n_pos = g_done4 ? 3'd0 : g_pos1;
                    if (g_done4) begin
                        if (r_phase == wkb_pkg::PH_OUTER_TYPE ||
                            r_phase == wkb_pkg::PH_SUB_TYPE) n_type = g_w32;
                        if ((r_phase == wkb_pkg::PH_OUTER_TYPE ||
                             r_phase == wkb_pkg::PH_SUB_TYPE) && g_w32[29]) begin
                            n_phase = (r_phase == wkb_pkg::PH_OUTER_TYPE)
                                      ? wkb_pkg::PH_OUTER_SRID : wkb_pkg::PH_SUB_SRID;
                        end else if (!c_hz || !c_hm) begin
                            ev_st = 1'b1; ev_code = wkb_pkg::ST_NOT_ZM;
                        end else if (c_sub) begin
                            if (c_base != 32'd2) begin
                                ev_st = 1'b1; ev_code = wkb_pkg::ST_UNSUP;
                            end else n_phase = wkb_pkg::PH_NPOINTS;
                        end else if (c_base == 32'd2) begin
                            n_multi = 1'b0; n_line = 32'd0; n_phase = wkb_pkg::PH_NPOINTS;
                        end else if (c_base == 32'd5) begin
                            n_multi = 1'b1; n_phase = wkb_pkg::PH_NLINES;
                        end else begin
                            ev_st = 1'b1; ev_code = wkb_pkg::ST_UNSUP;
                        end
                    end
                end
                wkb_pkg::PH_NLINES: begin
                    n_asm = g_word;
                    n_pos = g_done4 ? 3'd0 : g_pos1;
                    if (g_done4) begin
                        n_lines = g_w32; n_line = 32'd0;
                        if (g_w32 == 32'd0) ev_st = 1'b1;
                        else n_phase = wkb_pkg::PH_SUB_ENDIAN;
                    end
                end
                wkb_pkg::PH_NPOINTS: begin
                    n_asm = g_word;
                    n_pos = g_done4 ? 3'd0 : g_pos1;
                    if (g_done4) begin
                        if (g_w32 == 32'd0) begin
                            // empty line completes at once
                            if (!r_multi) ev_st = 1'b1;
                            else begin
                                n_lines = r_lines - 32'd1; n_line = r_line + 32'd1;
                                if (r_lines == 32'd1) ev_st = 1'b1;
                                else n_phase = wkb_pkg::PH_SUB_ENDIAN;
                            end
                        end else begin
                            n_pts = g_w32; n_point = 32'd0; n_csel = 2'd0;
                            n_phase = wkb_pkg::PH_COORD;
                        end
                    end
                end
                wkb_pkg::PH_COORD: begin
                    n_asm = g_word;
                    n_pos = g_pos1;
                    if (g_done8) begin
                        if (r_csel != 2'd3) begin
                            hold_we = 1'b1; n_csel = r_csel + 2'd1;
                        end else begin
                            ev_vtx = 1'b1; n_csel = 2'd0;
                            n_point = r_point + 32'd1; n_pts = r_pts - 32'd1;
                            if (r_pts == 32'd1) begin
                                if (!r_multi) ev_st = 1'b1;
                                else begin
                                    n_lines = r_lines - 32'd1; n_line = r_line + 32'd1;
                                    if (r_lines == 32'd1) ev_st = 1'b1;
                                    else n_phase = wkb_pkg::PH_SUB_ENDIAN;
                                end
                            end
                        end
                    end
                end
                default: begin
                    ev_st = 1'b1; ev_code = wkb_pkg::ST_UNSUP;
                end
            endcase
        end
        if (ev_st) n_fin = 1'b1;
        if (i_last && !r_fin && !ev_st) begin
            ev_st = 1'b1; ev_code = wkb_pkg::ST_TRUNC;
        end
    end

    always_comb begin
        o_event.has_vertex  = ev_vtx;
        o_event.has_status  = ev_st;
        o_event.status_code = ev_code;
        o_event.line_index  = r_line;
        o_event.point_index = r_point;
        o_event.x_bits      = r_held[0];
        o_event.y_bits      = r_held[1];
        o_event.z_bits      = r_held[2];
        o_event.m_bits      = g_word;
        o_event_any         = i_take && (ev_vtx || ev_st);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_take && i_last)) begin
            r_phase <= wkb_pkg::PH_OUTER_ENDIAN;
            r_pos <= '0; r_big <= 1'b0; r_asm <= '0; r_type <= '0; r_multi <= 1'b0;
            r_lines <= '0; r_pts <= '0; r_line <= '0; r_point <= '0;
            r_csel <= '0; r_fin <= 1'b0;
            r_held[0] <= '0; r_held[1] <= '0; r_held[2] <= '0;
        end else if (i_take) begin
            r_phase <= n_phase; r_pos <= n_pos; r_big <= n_big; r_asm <= n_asm;
            r_type <= n_type; r_multi <= n_multi; r_lines <= n_lines;
            r_pts <= n_pts; r_line <= n_line; r_point <= n_point;
            r_csel <= n_csel; r_fin <= n_fin;
            if (hold_we) r_held[r_csel] <= g_word;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin |-> !(o_event.has_vertex))
        else $error("vertex after stream finished");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != wkb_pkg::PH_COORD) |-> !o_event.has_vertex)
        else $error("vertex outside coordinate phase");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && i_last) |=> (r_phase == wkb_pkg::PH_OUTER_ENDIAN && !r_fin))
        else $error("state not reset after last byte");

endmodule

FILE: design/wkb_back.sv
// ----------------------------------------------------------------------------
// WKB back end
// Event queue and result serializer: one or two beats per event.
// ----------------------------------------------------------------------------
module wkb_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  wkb_pkg::t_event i_event,
    output logic            o_full,
    wkb_result_if.source    res
);

    localparam int AW = $clog2(wkb_pkg::QDEPTH);

    wkb_pkg::t_event r_q [wkb_pkg::QDEPTH];
    logic [AW-1:0]   r_wp, r_rp;
    logic [AW:0]     r_cnt, n_cnt;
    logic            r_sub, n_sub;   // vertex of head already sent
    wkb_pkg::t_event head;
    logic            pop, beat;

    always_comb begin
        head = r_q[r_rp];
        beat = res.valid && res.ready;
        pop  = beat && (!head.has_vertex || r_sub || !head.has_status);
        n_sub = r_sub;
        if (beat) n_sub = pop ? 1'b0 : 1'b1;
        n_cnt = r_cnt + {{AW{1'b0}}, i_push} - {{AW{1'b0}}, pop};
        o_full = (r_cnt == (AW+1)'(wkb_pkg::QDEPTH));
    end

    always_comb begin
        res.valid       = (r_cnt != '0);
        res.item_kind   = (head.has_vertex && !r_sub) ? wkb_pkg::KIND_VERTEX
                                                      : wkb_pkg::KIND_STATUS;
        res.last_of_run = !(head.has_vertex && !r_sub && head.has_status);
        if (res.item_kind == wkb_pkg::KIND_VERTEX) begin
            res.status_code = wkb_pkg::ST_OK;
            res.line_index  = head.line_index;
            res.point_index = head.point_index;
            res.x_bits = head.x_bits; res.y_bits = head.y_bits;
            res.z_bits = head.z_bits; res.m_bits = head.m_bits;
        end else begin
            res.status_code = head.status_code;
            res.line_index  = '0; res.point_index = '0;
            res.x_bits = '0; res.y_bits = '0; res.z_bits = '0; res.m_bits = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0; r_sub <= 1'b0;
        end else begin
            if (i_push) r_wp <= r_wp + AW'(1);
            if (pop)    r_rp <= r_rp + AW'(1);
            r_cnt <= n_cnt;
            r_sub <= n_sub;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_q[r_wp] <= i_event;
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (AW+1)'(wkb_pkg::QDEPTH))
        else $error("queue overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sub |-> (r_cnt != '0))
        else $error("split flag without entry");

endmodule
